FILE: design/path_oram_access_controller_unit_assert.svh
// assertion macros for the path oram access controller
// used by the control module; no other dependencies
`ifndef PATH_ORAM_ACCESS_CONTROLLER_UNIT_ASSERT_SVH
`define PATH_ORAM_ACCESS_CONTROLLER_UNIT_ASSERT_SVH

// same-cycle implication
`define POAC_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("%m: check failed");

// next-cycle implication
`define POAC_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

FILE: design/poac_pkg.sv
// shared types and codes for the path oram access controller
// no dependencies
package poac_pkg;

    localparam int ACT_W    = 3;
    localparam int ADDR_W   = 10;
    localparam int WORD_W   = 64;
    localparam int LEN_W    = 4;
    localparam int LEAF_W   = 10;
    localparam int LEVEL_W  = 4;
    localparam int OFF_W    = 10;
    localparam int SLOT_W   = 2;
    localparam int STATUS_W = 2;
    localparam int PEAK_W   = 7;

    localparam logic [ACT_W-1:0] ACT_READ   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_WRITE  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_DUMMY  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_LOAD   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_FINISH = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOINIT   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOTFOUND = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd3;

    localparam logic [PEAK_W-1:0] PEAK_MAX = 7'd127;

    typedef struct packed {
        logic [WORD_W-1:0]   read_word;
        logic [LEN_W-1:0]    read_length;
        logic [STATUS_W-1:0] status;
        logic [PEAK_W-1:0]   stash_peak;
    } result_t;

endpackage

FILE: design/poac_channels.sv
// handshake channels of the path oram access controller
// depends on poac_pkg
interface poac_req_if;
    logic                           valid;
    logic                           ready;
    logic [poac_pkg::ACT_W-1:0]     action;
    logic [poac_pkg::ADDR_W-1:0]    block_address;
    logic [poac_pkg::WORD_W-1:0]    write_word;
    logic [poac_pkg::LEN_W-1:0]     write_length;
    logic [poac_pkg::LEAF_W-1:0]    fresh_leaf;
    logic [poac_pkg::LEVEL_W-1:0]   load_level;
    logic [poac_pkg::OFF_W-1:0]     load_offset;
    logic [poac_pkg::SLOT_W-1:0]    load_slot;
    logic                           load_valid;

    modport source (output valid, action, block_address, write_word, write_length,
                    fresh_leaf, load_level, load_offset, load_slot, load_valid,
                    input ready);
    modport sink (input valid, action, block_address, write_word, write_length,
                  fresh_leaf, load_level, load_offset, load_slot, load_valid,
                  output ready);
endinterface

interface poac_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [poac_pkg::WORD_W-1:0]    read_word;
    logic [poac_pkg::LEN_W-1:0]     read_length;
    logic [poac_pkg::STATUS_W-1:0]  status;
    logic [poac_pkg::PEAK_W-1:0]    stash_peak;

    modport source (output valid, read_word, read_length, status, stash_peak,
                    input ready);
    modport sink (input valid, read_word, read_length, status, stash_peak,
                  output ready);
endinterface

interface poac_cfg_if;
    logic valid;
    logic ready;
    logic partition_mode;

    modport source (output valid, partition_mode, input ready);
    modport sink (input valid, partition_mode, output ready);
endinterface

FILE: design/poac_rsp_reg.sv
// output register holding one result transaction
// depends on poac_pkg and poac_rsp_if
module poac_rsp_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  poac_pkg::result_t data,
    output logic              free,
    poac_rsp_if.source        rsp
);

    logic              valid_reg;
    poac_pkg::result_t data_reg;

    assign free = !valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            data_reg  <= '0;
        end
        else if (push)
        begin
            valid_reg <= 1'b1;
            data_reg  <= data;
        end
        else if (rsp.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    assign rsp.valid       = valid_reg;
    assign rsp.read_word   = data_reg.read_word;
    assign rsp.read_length = data_reg.read_length;
    assign rsp.status      = data_reg.status;
    assign rsp.stash_peak  = data_reg.stash_peak;

endmodule

FILE: design/poac_ctrl.sv
// access sequencer with position table, bucket tree, presence map and stash memories
// depends on poac_pkg, the channel interfaces and the assertion macro header
`include "path_oram_access_controller_unit_assert.svh"

module poac_ctrl #(
    parameter int TREE_LEVELS  = 10,
    parameter int BUCKET_SLOTS = 4,
    parameter int STASH_DEPTH  = 64,
    parameter int BLOCK_COUNT  = 1024,
    parameter int DATA_BITS    = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    poac_req_if.sink          req,
    poac_cfg_if.sink          cfg,
    input  logic              rsp_free,
    output logic              rsp_push,
    output poac_pkg::result_t rsp_data
);

    localparam int LW      = TREE_LEVELS;
    localparam int SLOTS   = ((2 << TREE_LEVELS) - 1) * BUCKET_SLOTS;
    localparam int SIW     = $clog2(SLOTS);
    localparam int AW      = $clog2(BLOCK_COUNT);
    localparam int SDW     = $clog2(STASH_DEPTH);
    localparam int CW      = $clog2(STASH_DEPTH + 1);
    localparam int LVW     = $clog2(TREE_LEVELS + 1);
    localparam int UW      = $clog2(BUCKET_SLOTS + 1);
    localparam int LEN_W   = poac_pkg::LEN_W;
    localparam int SEW     = AW + DATA_BITS + LEN_W;
    localparam int TEW     = 1 + SEW;
    localparam int CLRN    = (SLOTS > BLOCK_COUNT) ? SLOTS : BLOCK_COUNT;
    localparam int CLW     = $clog2(CLRN + 1);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(DATA_BITS / 8);

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_LOAD, ST_POS_RD, ST_POS_GET, ST_PATH_RD, ST_PATH_CHK,
        ST_PATH_PRES, ST_FIND_RD, ST_FIND_CHK, ST_SH_RD, ST_SH_WR, ST_EV_LVL,
        ST_EV_RD, ST_EV_POS, ST_EV_DEC, ST_EV_FILL, ST_RESP
    } state_t;

    state_t                         state_reg;
    logic [CLW-1:0]                 clr_reg;
    logic [poac_pkg::ACT_W-1:0]     act_reg;
    logic [AW-1:0]                  addr_reg;
    logic [DATA_BITS-1:0]           word_reg;
    logic [LEN_W-1:0]               len_reg;
    logic [LW-1:0]                  leaf_reg;
    logic [SIW-1:0]                 load_idx_reg;
    logic                           load_ok_reg;
    logic                           load_valid_reg;
    logic                           in_range_reg;
    logic [LW-1:0]                  x_reg;
    logic [LVW-1:0]                 lvl_reg;
    logic [UW-1:0]                  slot_reg;
    logic [UW-1:0]                  used_reg;
    logic [CW-1:0]                  r_reg;
    logic [CW-1:0]                  keep_reg;
    logic [CW-1:0]                  cnt_reg;
    logic                           over_reg;
    logic [SEW-1:0]                 ent_reg;
    logic                           ready_flag_reg;
    logic [poac_pkg::PEAK_W-1:0]    peak_reg;
    logic                           part_reg;
    logic [DATA_BITS-1:0]           res_word_reg;
    logic [LEN_W-1:0]               res_len_reg;
    logic [poac_pkg::STATUS_W-1:0]  res_status_reg;

    // memories
    logic [TEW-1:0]       tree_mem [SLOTS];
    logic [LW-1:0]        pos_mem  [BLOCK_COUNT];
    logic                 pres_mem [BLOCK_COUNT];
    logic [SEW-1:0]       st_mem   [STASH_DEPTH];

    logic                 tree_we;
    logic [SIW-1:0]       tree_waddr;
    logic [SIW-1:0]       tree_raddr;
    logic [TEW-1:0]       tree_wdata;
    logic [TEW-1:0]       tree_q;
    logic                 pos_we;
    logic [AW-1:0]        pos_waddr;
    logic [AW-1:0]        pos_raddr;
    logic [LW-1:0]        pos_wdata;
    logic [LW-1:0]        pos_q;
    logic                 pres_we;
    logic [AW-1:0]        pres_waddr;
    logic [AW-1:0]        pres_raddr;
    logic                 pres_wdata;
    logic                 pres_q;
    logic                 st_we;
    logic [SDW-1:0]       st_waddr;
    logic [SDW-1:0]       st_raddr;
    logic [SEW-1:0]       st_wdata;
    logic [SEW-1:0]       st_q;

    logic [31:0]          in_addr32;
    logic [31:0]          in_leaf32;
    logic [31:0]          ld_lvl32;
    logic [31:0]          ld_off32;
    logic [31:0]          ld_slot32;
    logic [31:0]          ld_idx32;
    logic                 in_range;
    logic                 ld_ok;
    logic [LEN_W-1:0]     in_len;
    logic [UW-1:0]        cur_slot;
    logic [SIW-1:0]       cur_idx;
    logic [31:0]          sh32;
    logic                 ev_match;
    logic [AW-1:0]        ent_addr;
    logic [AW-1:0]        stq_addr;
    logic [CW-1:0]        r_prev;

    function automatic logic [SIW-1:0] slot_index(input logic [LVW-1:0] lv,
                                                  input logic [LW-1:0] leaf,
                                                  input logic [UW-1:0] s);
        logic [31:0] sh;
        logic [31:0] bkt;
        logic [31:0] idx;
        sh  = 32'(TREE_LEVELS) - 32'(lv);
        bkt = ((32'd1 << lv) - 32'd1) + (32'(leaf) >> sh);
        idx = bkt * 32'(BUCKET_SLOTS) + 32'(s);
        return idx[SIW-1:0];
    endfunction

    // input decode
    assign in_addr32 = 32'(req.block_address);
    assign in_leaf32 = 32'(req.fresh_leaf);
    assign ld_lvl32  = 32'(req.load_level);
    assign ld_off32  = 32'(req.load_offset);
    assign ld_slot32 = 32'(req.load_slot);
    assign in_range  = in_addr32 < 32'(BLOCK_COUNT);
    assign ld_ok     = (ld_lvl32 <= 32'(TREE_LEVELS)) && (ld_off32 < (32'd1 << ld_lvl32))
                       && (ld_slot32 < 32'(BUCKET_SLOTS));
    assign ld_idx32  = ((32'd1 << ld_lvl32) - 32'd1 + ld_off32) * 32'(BUCKET_SLOTS)
                       + ld_slot32;
    assign in_len    = (req.write_length > LEN_MAX) ? LEN_MAX : req.write_length;

    assign cur_slot  = (state_reg == ST_PATH_RD) ? slot_reg : used_reg;
    assign cur_idx   = slot_index(lvl_reg, x_reg, cur_slot);
    assign sh32      = 32'(TREE_LEVELS) - 32'(lvl_reg);
    assign ev_match  = (used_reg < UW'(BUCKET_SLOTS))
                       && ((32'(pos_q) >> sh32) == (32'(x_reg) >> sh32));
    assign ent_addr  = ent_reg[SEW-1 -: AW];
    assign stq_addr  = st_q[SEW-1 -: AW];
    assign r_prev    = r_reg - CW'(1);

    assign req.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;

    assign rsp_push  = (state_reg == ST_RESP) && rsp_free;
    assign rsp_data  = '{read_word:   poac_pkg::WORD_W'(res_word_reg),
                         read_length: res_len_reg,
                         status:      res_status_reg,
                         stash_peak:  peak_reg};

    // memory port control
    always_comb
    begin
        tree_we    = 1'b0;
        tree_waddr = cur_idx;
        tree_wdata = {1'b1, ent_reg};
        tree_raddr = cur_idx;
        pos_we     = 1'b0;
        pos_waddr  = addr_reg;
        pos_wdata  = leaf_reg;
        pos_raddr  = addr_reg;
        pres_we    = 1'b0;
        pres_waddr = ent_addr;
        pres_wdata = 1'b0;
        pres_raddr = tree_q[SEW-1 -: AW];
        st_we      = 1'b0;
        st_waddr   = keep_reg[SDW-1:0];
        st_wdata   = ent_reg;
        st_raddr   = r_reg[SDW-1:0];
        case (state_reg)
            ST_CLEAR:
            begin
                tree_we    = clr_reg < CLW'(SLOTS);
                tree_waddr = clr_reg[SIW-1:0];
                tree_wdata = '0;
                pos_we     = clr_reg < CLW'(BLOCK_COUNT);
                pos_waddr  = clr_reg[AW-1:0];
                pos_wdata  = '0;
                pres_we    = clr_reg < CLW'(BLOCK_COUNT);
                pres_waddr = clr_reg[AW-1:0];
            end
            ST_LOAD:
            begin
                tree_we    = load_ok_reg && (!load_valid_reg || in_range_reg);
                tree_waddr = load_idx_reg;
                tree_wdata = {load_valid_reg, addr_reg, word_reg, len_reg};
                pos_we     = load_ok_reg && load_valid_reg && in_range_reg;
            end
            ST_POS_GET:
            begin
                pos_we = 1'b1;
            end
            ST_PATH_PRES:
            begin
                st_we      = !pres_q && (cnt_reg < CW'(STASH_DEPTH));
                st_waddr   = cnt_reg[SDW-1:0];
                pres_we    = st_we;
                pres_wdata = 1'b1;
            end
            ST_FIND_CHK:
            begin
                st_we    = (stq_addr == addr_reg) && (act_reg == poac_pkg::ACT_WRITE);
                st_waddr = r_reg[SDW-1:0];
                st_wdata = {addr_reg, word_reg, len_reg};
            end
            ST_SH_RD:
            begin
                pos_we     = (r_reg == cnt_reg);
                pos_wdata  = '0;
                pres_we    = (r_reg == cnt_reg);
                pres_waddr = addr_reg;
            end
            ST_SH_WR:
            begin
                st_we    = 1'b1;
                st_waddr = r_prev[SDW-1:0];
                st_wdata = st_q;
            end
            ST_EV_POS:
            begin
                pos_raddr = stq_addr;
            end
            ST_EV_DEC:
            begin
                tree_we = ev_match;
                pres_we = ev_match;
                st_we   = !ev_match;
            end
            ST_EV_FILL:
            begin
                tree_we    = (used_reg != UW'(BUCKET_SLOTS));
                tree_wdata = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (tree_we)
        begin
            tree_mem[tree_waddr] <= tree_wdata;
        end
        tree_q <= tree_mem[tree_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (pos_we)
        begin
            pos_mem[pos_waddr] <= pos_wdata;
        end
        pos_q <= pos_mem[pos_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (pres_we)
        begin
            pres_mem[pres_waddr] <= pres_wdata;
        end
        pres_q <= pres_mem[pres_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            st_mem[st_waddr] <= st_wdata;
        end
        st_q <= st_mem[st_raddr];
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_reg        <= '0;
            act_reg        <= '0;
            addr_reg       <= '0;
            word_reg       <= '0;
            len_reg        <= '0;
            leaf_reg       <= '0;
            load_idx_reg   <= '0;
            load_ok_reg    <= 1'b0;
            load_valid_reg <= 1'b0;
            in_range_reg   <= 1'b0;
            x_reg          <= '0;
            lvl_reg        <= '0;
            slot_reg       <= '0;
            used_reg       <= '0;
            r_reg          <= '0;
            keep_reg       <= '0;
            cnt_reg        <= '0;
            over_reg       <= 1'b0;
            ent_reg        <= '0;
            ready_flag_reg <= 1'b0;
            peak_reg       <= '0;
            part_reg       <= 1'b0;
            res_word_reg   <= '0;
            res_len_reg    <= '0;
            res_status_reg <= poac_pkg::STATUS_OK;
        end
        else
        begin
            if (cfg.valid)
            begin
                part_reg <= cfg.partition_mode;
            end
            case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + CLW'(1);
                    if (clr_reg == CLW'(CLRN - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (req.valid)
                    begin
                        act_reg        <= req.action;
                        addr_reg       <= in_addr32[AW-1:0];
                        word_reg       <= req.write_word[DATA_BITS-1:0];
                        len_reg        <= in_len;
                        leaf_reg       <= in_leaf32[LW-1:0];
                        load_idx_reg   <= ld_idx32[SIW-1:0];
                        load_ok_reg    <= ld_ok;
                        load_valid_reg <= req.load_valid;
                        in_range_reg   <= in_range;
                        res_word_reg   <= '0;
                        res_len_reg    <= '0;
                        res_status_reg <= poac_pkg::STATUS_OK;
                        case (req.action)
                            poac_pkg::ACT_LOAD:
                            begin
                                state_reg <= ST_LOAD;
                            end
                            poac_pkg::ACT_FINISH:
                            begin
                                ready_flag_reg <= 1'b1;
                                state_reg      <= ST_RESP;
                            end
                            poac_pkg::ACT_READ, poac_pkg::ACT_WRITE, poac_pkg::ACT_DUMMY:
                            begin
                                if (!ready_flag_reg)
                                begin
                                    res_status_reg <= poac_pkg::STATUS_NOINIT;
                                    state_reg      <= ST_RESP;
                                end
                                else if (req.action == poac_pkg::ACT_DUMMY)
                                begin
                                    state_reg <= ST_RESP;
                                end
                                else if (!in_range)
                                begin
                                    res_status_reg <= poac_pkg::STATUS_NOTFOUND;
                                    state_reg      <= ST_RESP;
                                end
                                else
                                begin
                                    state_reg <= ST_POS_RD;
                                end
                            end
                            default:
                            begin
                                state_reg <= ST_RESP;
                            end
                        endcase
                    end
                end
                ST_LOAD:
                begin
                    state_reg <= ST_RESP;
                end
                ST_POS_RD:
                begin
                    state_reg <= ST_POS_GET;
                end
                ST_POS_GET:
                begin
                    x_reg     <= pos_q;
                    lvl_reg   <= '0;
                    slot_reg  <= '0;
                    over_reg  <= 1'b0;
                    state_reg <= ST_PATH_RD;
                end
                ST_PATH_RD:
                begin
                    state_reg <= ST_PATH_CHK;
                end
                ST_PATH_CHK, ST_PATH_PRES:
                begin
                    if ((state_reg == ST_PATH_CHK) && tree_q[TEW-1])
                    begin
                        ent_reg   <= tree_q[SEW-1:0];
                        state_reg <= ST_PATH_PRES;
                    end
                    else
                    begin
                        if ((state_reg == ST_PATH_PRES) && !pres_q)
                        begin
                            if (cnt_reg < CW'(STASH_DEPTH))
                            begin
                                cnt_reg <= cnt_reg + CW'(1);
                            end
                            else
                            begin
                                over_reg <= 1'b1;
                            end
                        end
                        state_reg <= ST_PATH_RD;
                        if (slot_reg == UW'(BUCKET_SLOTS - 1))
                        begin
                            slot_reg <= '0;
                            if (lvl_reg == LVW'(TREE_LEVELS))
                            begin
                                r_reg     <= '0;
                                state_reg <= ST_FIND_RD;
                            end
                            else
                            begin
                                lvl_reg <= lvl_reg + LVW'(1);
                            end
                        end
                        else
                        begin
                            slot_reg <= slot_reg + UW'(1);
                        end
                    end
                end
                ST_FIND_RD:
                begin
                    if (r_reg == cnt_reg)
                    begin
                        res_status_reg <= poac_pkg::STATUS_NOTFOUND;
                        state_reg      <= ST_RESP;
                    end
                    else
                    begin
                        state_reg <= ST_FIND_CHK;
                    end
                end
                ST_FIND_CHK:
                begin
                    if (stq_addr == addr_reg)
                    begin
                        if (32'(cnt_reg) > 32'(peak_reg))
                        begin
                            peak_reg <= (32'(cnt_reg) > 32'(poac_pkg::PEAK_MAX))
                                        ? poac_pkg::PEAK_MAX
                                        : poac_pkg::PEAK_W'(cnt_reg);
                        end
                        lvl_reg   <= LVW'(TREE_LEVELS);
                        state_reg <= ST_EV_LVL;
                        if (act_reg == poac_pkg::ACT_READ)
                        begin
                            res_word_reg <= st_q[LEN_W +: DATA_BITS];
                            res_len_reg  <= st_q[LEN_W-1:0];
                            if (part_reg)
                            begin
                                r_reg     <= r_reg + CW'(1);
                                state_reg <= ST_SH_RD;
                            end
                        end
                    end
                    else
                    begin
                        r_reg     <= r_reg + CW'(1);
                        state_reg <= ST_FIND_RD;
                    end
                end
                ST_SH_RD:
                begin
                    if (r_reg == cnt_reg)
                    begin
                        cnt_reg   <= cnt_reg - CW'(1);
                        state_reg <= ST_EV_LVL;
                    end
                    else
                    begin
                        state_reg <= ST_SH_WR;
                    end
                end
                ST_SH_WR:
                begin
                    r_reg     <= r_reg + CW'(1);
                    state_reg <= ST_SH_RD;
                end
                ST_EV_LVL:
                begin
                    r_reg     <= '0;
                    keep_reg  <= '0;
                    used_reg  <= '0;
                    state_reg <= ST_EV_RD;
                end
                ST_EV_RD:
                begin
                    if (r_reg == cnt_reg)
                    begin
                        cnt_reg   <= keep_reg;
                        state_reg <= ST_EV_FILL;
                    end
                    else
                    begin
                        state_reg <= ST_EV_POS;
                    end
                end
                ST_EV_POS:
                begin
                    ent_reg   <= st_q;
                    state_reg <= ST_EV_DEC;
                end
                ST_EV_DEC:
                begin
                    if (ev_match)
                    begin
                        used_reg <= used_reg + UW'(1);
                    end
                    else
                    begin
                        keep_reg <= keep_reg + CW'(1);
                    end
                    r_reg     <= r_reg + CW'(1);
                    state_reg <= ST_EV_RD;
                end
                ST_EV_FILL:
                begin
                    if (used_reg == UW'(BUCKET_SLOTS))
                    begin
                        if (lvl_reg == '0)
                        begin
                            res_status_reg <= over_reg ? poac_pkg::STATUS_OVERFLOW
                                                       : poac_pkg::STATUS_OK;
                            state_reg      <= ST_RESP;
                        end
                        else
                        begin
                            lvl_reg   <= lvl_reg - LVW'(1);
                            state_reg <= ST_EV_LVL;
                        end
                    end
                    else
                    begin
                        used_reg <= used_reg + UW'(1);
                    end
                end
                ST_RESP:
                begin
                    if (rsp_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `POAC_ASSERT_IMP(a_stash_bound, clk, rst_n, 1'b1, cnt_reg <= CW'(STASH_DEPTH))
    `POAC_ASSERT_IMP(a_used_bound, clk, rst_n, 1'b1, used_reg <= UW'(BUCKET_SLOTS))
    `POAC_ASSERT_NXT(a_accept_busy, clk, rst_n, req.valid && req.ready, state_reg != ST_IDLE)
    `POAC_ASSERT_IMP(a_push_free, clk, rst_n, rsp_push, rsp_free && (state_reg == ST_RESP))

endmodule

FILE: design/path_oram_access_controller_unit.sv
// Path ORAM access controller with the bucket tree, position table and stash on chip.
// After reset the block runs a clearing pass over max(slot count, BLOCK_COUNT) addresses
// (8188 at the defaults) before it takes the first transaction; configuration writes
// are taken at any time. One transaction is processed at a time. An access walks the
// memories one entry at a time: the path read visits every slot of each level, the
// stash is searched entry by entry to find the block, and eviction, per level from the
// leaf up to the root, passes over the stash entries and then fills the remaining slots
// with empty entries, as the stash, position and tree memories each have a registered read.
// Depends on poac_pkg, the channel interfaces, poac_ctrl and poac_rsp_reg.
module path_oram_access_controller_unit #(
    parameter int TREE_LEVELS  = 10,
    parameter int BUCKET_SLOTS = 4,
    parameter int STASH_DEPTH  = 64,
    parameter int BLOCK_COUNT  = 1024,
    parameter int DATA_BITS    = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    poac_req_if.sink   req,
    poac_cfg_if.sink   cfg,
    poac_rsp_if.source rsp
);

    logic              rsp_free;
    logic              rsp_push;
    poac_pkg::result_t rsp_data;

    poac_ctrl #(
        .TREE_LEVELS  (TREE_LEVELS),
        .BUCKET_SLOTS (BUCKET_SLOTS),
        .STASH_DEPTH  (STASH_DEPTH),
        .BLOCK_COUNT  (BLOCK_COUNT),
        .DATA_BITS    (DATA_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .cfg      (cfg),
        .rsp_free (rsp_free),
        .rsp_push (rsp_push),
        .rsp_data (rsp_data)
    );

    poac_rsp_reg u_rsp (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (rsp_push),
        .data  (rsp_data),
        .free  (rsp_free),
        .rsp   (rsp)
    );

endmodule
